// ===== design/htd_pkg.sv =====
// ----------------------------------------------------------------------------
// htd_pkg
// shared types and constants of the huffman code tree decoder
// ----------------------------------------------------------------------------
`default_nettype none

package htd_pkg;

    localparam int NODE_COUNT      = 512;
    localparam int IDX_W           = $clog2(NODE_COUNT);
    localparam int USED_W          = $clog2(NODE_COUNT + 1);
    localparam int MAX_CODE_LENGTH = 32;
    localparam int SYM_W           = 8;
    localparam int CODE_W          = 32;
    localparam int LEN_W           = 6;
    localparam int POS_W           = $clog2(CODE_W);
    localparam int OP_W            = 2;
    localparam int STATUS_W        = 2;

    // s_tdata layout
    localparam int SYM_LO  = 0;
    localparam int CODE_LO = SYM_LO + SYM_W;
    localparam int LEN_LO  = CODE_LO + CODE_W;
    localparam int BIT_LO  = LEN_LO + LEN_W;
    localparam int S_DATA_W = ((BIT_LO + 1 + 7) / 8) * 8;
    localparam int M_DATA_W = ((SYM_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_DECODE = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LD_STEP,
        S_DEC_CUR,
        S_DEC_NXT
    } state_t;

    typedef struct packed {
        logic [SYM_W-1:0]           sym;
        logic [1:0]                 present;
        logic [1:0][IDX_W-1:0]      link;
    } node_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        node_t            data;
    } ram_wr_t;

    typedef struct packed {
        logic             re;
        logic [IDX_W-1:0] addr;
    } ram_rd_t;

    typedef struct packed {
        logic             valid;
        logic [SYM_W-1:0] sym;
        status_t          status;
    } result_t;

endpackage

`default_nettype wire

// ===== design/htd_node_ram.sv =====
// ----------------------------------------------------------------------------
// htd_node_ram
// node store, one write and one registered read port, root reads empty
// until written after reset or clear
// ----------------------------------------------------------------------------
`default_nettype none

module htd_node_ram (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            clear,
    input  wire htd_pkg::ram_wr_t wr,
    input  wire htd_pkg::ram_rd_t rd,
    output htd_pkg::node_t       rdata
);

    htd_pkg::node_t mem [htd_pkg::NODE_COUNT];
    htd_pkg::node_t rdata_reg;
    logic           root_valid_reg;
    logic           root_valid_next;
    logic           rd_zero_reg;
    logic           rd_zero_next;

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.re) begin
            rdata_reg <= mem[rd.addr];
        end
    end

    always_comb begin
        root_valid_next = root_valid_reg;
        rd_zero_next    = rd_zero_reg;
        if (clear) begin
            root_valid_next = 1'b0;
        end else if (wr.we && (wr.addr == '0)) begin
            root_valid_next = 1'b1;
        end
        if (rd.re) begin
            rd_zero_next = (rd.addr == '0) && !root_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_valid_reg <= 1'b0;
            rd_zero_reg    <= 1'b0;
        end else begin
            root_valid_reg <= root_valid_next;
            rd_zero_reg    <= rd_zero_next;
        end
    end

    assign rdata = rd_zero_reg ? '0 : rdata_reg;

endmodule

`default_nettype wire

// ===== design/htd_ctrl.sv =====
// ----------------------------------------------------------------------------
// htd_ctrl
// sequencer for tree load walks, decode steps and clears
// ----------------------------------------------------------------------------
`default_nettype none

module htd_ctrl (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [htd_pkg::S_DATA_W-1:0]      s_tdata,
    input  wire logic [htd_pkg::OP_W-1:0]          s_tuser,
    input  wire logic                              res_ready,
    output htd_pkg::result_t                       res,
    output htd_pkg::ram_wr_t                       wr,
    output htd_pkg::ram_rd_t                       rd,
    output logic                                   ram_clear,
    input  wire htd_pkg::node_t                    rdata
);

    htd_pkg::state_t                  state_reg, state_next;
    logic [htd_pkg::LEN_W-1:0]        cnt_reg, cnt_next;
    logic [htd_pkg::CODE_W-1:0]       code_reg, code_next;
    logic [htd_pkg::SYM_W-1:0]        sym_reg, sym_next;
    logic [htd_pkg::IDX_W-1:0]        node_reg, node_next;
    htd_pkg::node_t                   walk_reg, walk_next;
    logic                             use_rd_reg, use_rd_next;
    logic [htd_pkg::USED_W-1:0]       used_reg, used_next;
    logic [htd_pkg::IDX_W-1:0]        cur_reg, cur_next;
    logic [htd_pkg::IDX_W-1:0]        nxt_reg, nxt_next;
    htd_pkg::node_t                   cache_reg, cache_next;
    logic                             cache_valid_reg, cache_valid_next;
    logic                             bit_reg, bit_next;

    logic                      accept;
    htd_pkg::op_t              op;
    logic [htd_pkg::LEN_W-1:0] len_in;
    logic [htd_pkg::LEN_W-1:0] pos;
    logic                      ld_bit;
    htd_pkg::node_t            ld_node;
    htd_pkg::node_t            ld_mod;
    htd_pkg::node_t            dec_node;
    logic                      full;

    assign s_tready = (state_reg == htd_pkg::S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign op       = htd_pkg::op_t'(s_tuser);
    assign len_in   = s_tdata[htd_pkg::LEN_LO +: htd_pkg::LEN_W];
    assign pos      = cnt_reg - htd_pkg::LEN_W'(1);
    assign ld_bit   = (pos < htd_pkg::LEN_W'(htd_pkg::CODE_W))
                    ? code_reg[pos[htd_pkg::POS_W-1:0]] : 1'b0;
    assign ld_node  = use_rd_reg ? rdata : walk_reg;
    assign dec_node = use_rd_reg ? rdata : cache_reg;
    assign full     = (used_reg >= htd_pkg::USED_W'(htd_pkg::NODE_COUNT));

    always_comb begin
        ld_mod               = ld_node;
        ld_mod.present[ld_bit] = 1'b1;
        ld_mod.link[ld_bit]  = used_reg[htd_pkg::IDX_W-1:0];
    end

    always_comb begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        code_next        = code_reg;
        sym_next         = sym_reg;
        node_next        = node_reg;
        walk_next        = walk_reg;
        use_rd_next      = use_rd_reg;
        used_next        = used_reg;
        cur_next         = cur_reg;
        nxt_next         = nxt_reg;
        cache_next       = cache_reg;
        cache_valid_next = cache_valid_reg;
        bit_next         = bit_reg;
        res              = '0;
        wr               = '0;
        rd               = '0;
        ram_clear        = 1'b0;

        unique case (state_reg)
            htd_pkg::S_IDLE: begin
                if (accept) begin
                    case (op)
                        htd_pkg::OP_CLEAR: begin
                            ram_clear        = 1'b1;
                            used_next        = htd_pkg::USED_W'(1);
                            cur_next         = '0;
                            cache_valid_next = 1'b0;
                        end
                        htd_pkg::OP_LOAD: begin
                            cache_valid_next = 1'b0;
                            sym_next  = s_tdata[htd_pkg::SYM_LO +: htd_pkg::SYM_W];
                            code_next = s_tdata[htd_pkg::CODE_LO +: htd_pkg::CODE_W];
                            cnt_next  = (len_in > htd_pkg::LEN_W'(htd_pkg::MAX_CODE_LENGTH))
                                      ? htd_pkg::LEN_W'(htd_pkg::MAX_CODE_LENGTH) : len_in;
                            node_next   = '0;
                            rd.re       = 1'b1;
                            rd.addr     = '0;
                            use_rd_next = 1'b1;
                            state_next  = htd_pkg::S_LD_STEP;
                        end
                        htd_pkg::OP_DECODE: begin
                            bit_next = s_tdata[htd_pkg::BIT_LO];
                            if (cache_valid_reg) begin
                                use_rd_next = 1'b0;
                            end else begin
                                rd.re       = 1'b1;
                                rd.addr     = cur_reg;
                                use_rd_next = 1'b1;
                            end
                            state_next = htd_pkg::S_DEC_CUR;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            htd_pkg::S_LD_STEP: begin
                if (cnt_reg == '0) begin
                    wr.we      = 1'b1;
                    wr.addr    = node_reg;
                    wr.data    = ld_node;
                    wr.data.sym = sym_reg;
                    state_next = htd_pkg::S_IDLE;
                end else if (ld_node.present[ld_bit]) begin
                    rd.re       = 1'b1;
                    rd.addr     = ld_node.link[ld_bit];
                    node_next   = ld_node.link[ld_bit];
                    use_rd_next = 1'b1;
                    cnt_next    = pos;
                end else if (full) begin
                    if (res_ready) begin
                        res.valid  = 1'b1;
                        res.sym    = '0;
                        res.status = htd_pkg::ST_FULL;
                        wr.we      = 1'b1;
                        wr.addr    = node_reg;
                        wr.data    = ld_node;
                        state_next = htd_pkg::S_IDLE;
                    end
                end else begin
                    wr.we       = 1'b1;
                    wr.addr     = node_reg;
                    wr.data     = ld_mod;
                    node_next   = used_reg[htd_pkg::IDX_W-1:0];
                    walk_next   = '0;
                    use_rd_next = 1'b0;
                    used_next   = used_reg + htd_pkg::USED_W'(1);
                    cnt_next    = pos;
                end
            end

            htd_pkg::S_DEC_CUR: begin
                if (dec_node.present == 2'b00) begin
                    if (res_ready) begin
                        res.valid        = 1'b1;
                        res.sym          = dec_node.sym;
                        res.status       = htd_pkg::ST_OK;
                        cur_next         = '0;
                        cache_valid_next = 1'b0;
                        state_next       = htd_pkg::S_IDLE;
                    end
                end else if (!dec_node.present[bit_reg]) begin
                    if (res_ready) begin
                        res.valid        = 1'b1;
                        res.sym          = '0;
                        res.status       = htd_pkg::ST_MISS;
                        cur_next         = '0;
                        cache_valid_next = 1'b0;
                        state_next       = htd_pkg::S_IDLE;
                    end
                end else begin
                    rd.re      = 1'b1;
                    rd.addr    = dec_node.link[bit_reg];
                    nxt_next   = dec_node.link[bit_reg];
                    state_next = htd_pkg::S_DEC_NXT;
                end
            end

            htd_pkg::S_DEC_NXT: begin
                if (rdata.present == 2'b00) begin
                    if (res_ready) begin
                        res.valid        = 1'b1;
                        res.sym          = rdata.sym;
                        res.status       = htd_pkg::ST_OK;
                        cur_next         = '0;
                        cache_valid_next = 1'b0;
                        state_next       = htd_pkg::S_IDLE;
                    end
                end else begin
                    cur_next         = nxt_reg;
                    cache_next       = rdata;
                    cache_valid_next = 1'b1;
                    state_next       = htd_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = htd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= htd_pkg::S_IDLE;
            used_reg        <= htd_pkg::USED_W'(1);
            cur_reg         <= '0;
            cache_valid_reg <= 1'b0;
            use_rd_reg      <= 1'b0;
        end else begin
            state_reg       <= state_next;
            used_reg        <= used_next;
            cur_reg         <= cur_next;
            cache_valid_reg <= cache_valid_next;
            use_rd_reg      <= use_rd_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg   <= cnt_next;
        code_reg  <= code_next;
        sym_reg   <= sym_next;
        node_reg  <= node_next;
        walk_reg  <= walk_next;
        nxt_reg   <= nxt_next;
        cache_reg <= cache_next;
        bit_reg   <= bit_next;
    end

endmodule

`default_nettype wire

// ===== design/huffman_tree_decoder_core.sv =====
// ----------------------------------------------------------------------------
// huffman_tree_decoder_core
// code tree builder and bit-serial decoder around a single node store
// ----------------------------------------------------------------------------
//  channel   dir   fields
//  s_        in    tuser: operation; tdata: symbol, code_bits, code_length, bit_req
//  m_        out   tuser: status; tdata: decoded_symbol
//
//  decode: a taken branch steps through S_DEC_CUR and S_DEC_NXT, a current node that
//  is a leaf or lacks the branch ends in S_DEC_CUR; each branch costs one read of the
//  node store; load: one node visited per cycle unless a full store waits on output;
//  clear ends on acceptance; reset empties the tree at once, no sweep of the store
//  a held result stalls the sequencer only when a second result is due
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_tree_decoder_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // symbol, code_bits, code_length, bit_req
    input  wire logic [htd_pkg::S_DATA_W-1:0]   s_tdata,
    // operation
    input  wire logic [htd_pkg::OP_W-1:0]       s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // decoded_symbol
    output logic [htd_pkg::M_DATA_W-1:0]        m_tdata,
    // status
    output logic [htd_pkg::STATUS_W-1:0]        m_tuser
);

    htd_pkg::result_t res;
    htd_pkg::ram_wr_t wr;
    htd_pkg::ram_rd_t rd;
    htd_pkg::node_t   rdata;
    logic             ram_clear;
    logic             res_ready;

    logic                         out_valid_reg, out_valid_next;
    logic [htd_pkg::SYM_W-1:0]    out_sym_reg, out_sym_next;
    logic [htd_pkg::STATUS_W-1:0] out_status_reg, out_status_next;

    htd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .res_ready (res_ready),
        .res       (res),
        .wr        (wr),
        .rd        (rd),
        .ram_clear (ram_clear),
        .rdata     (rdata)
    );

    htd_node_ram u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (ram_clear),
        .wr      (wr),
        .rd      (rd),
        .rdata   (rdata)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_sym_next    = out_sym_reg;
        out_status_next = out_status_reg;
        if (res.valid) begin
            out_valid_next  = 1'b1;
            out_sym_next    = res.sym;
            out_status_next = res.status;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_sym_reg    <= out_sym_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = htd_pkg::M_DATA_W'(out_sym_reg);
    assign m_tuser  = out_status_reg;

`ifndef SYNTHESIS
    a_no_same_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr.we && rd.re && (wr.addr == rd.addr)))
        else $error("node store read and write hit the same entry");

    a_res_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> res_ready)
        else $error("result issued while output register is full");

    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !wr.we)
        else $error("node store written while sequencer is idle");

    a_clear_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_clear |=> s_tready)
        else $error("sequencer busy after clear");
`endif

endmodule

`default_nettype wire
